>>> hdl/asqm_pkg.sv
`default_nettype none
package asqm_pkg;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_PACKET = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 20;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ENABLED       = 3'd0,
		CFG_CLIP_LEVEL    = 3'd1,
		CFG_SILENCE_LEVEL = 3'd2,
		CFG_JITTER_DELTA  = 3'd3,
		CFG_GAP_LIMIT     = 3'd4
	} cfg_index_t;

	localparam int LEVEL_BITS     = 19;
	localparam int JITTER_BITS    = 20;
	localparam int GAP_LIMIT_BITS = 16;
	localparam int TS_BITS        = 48;

	localparam logic [LEVEL_BITS-1:0]     CLIP_LEVEL_RST    = 19'd65536;
	localparam logic [LEVEL_BITS-1:0]     SILENCE_LEVEL_RST = 19'd66;
	localparam logic [JITTER_BITS-1:0]    JITTER_DELTA_RST  = 20'd32768;
	localparam logic [GAP_LIMIT_BITS-1:0] GAP_LIMIT_RST     = 16'd100;

	// us -> ms: drop three bits, then divide by 125 in two reciprocal steps
	localparam int TS_SHIFT    = 3;
	localparam int X_BITS      = TS_BITS - TS_SHIFT;
	localparam int XL_BITS     = 24;
	localparam int XH_BITS     = X_BITS - XL_BITS;
	localparam int Q1_BITS     = 15;
	localparam int REM_BITS    = 7;
	localparam int Y_BITS      = REM_BITS + XL_BITS;
	localparam int Q2_BITS     = XL_BITS;
	localparam int QUOT_BITS   = Q1_BITS + Q2_BITS;
	localparam int RECIP_BITS  = 26;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_BITS-1:0] RECIP_125 = 26'd34359738;
	localparam logic [31:0]           DIVISOR   = 32'd125;

	localparam int DIV_STAGES = 5;

	typedef struct packed {
		logic [DIV_STAGES-1:0] load;
	} div_ctl_t;

endpackage
`default_nettype wire

>>> hdl/audio_stream_quality_monitor.sv
// Two-channel audio quality monitor (sent path, received path).
// Input channel: one beat per item on in_valid/in_stall carrying action, channel,
// sample and timestamp_us. Sample beats update count, peak, clip, silence and
// jitter statistics; packet beats measure the gap to the previous packet in ms;
// clear beats zero every channel. Output channel: one beat per item on
// out_valid/out_stall with the addressed channel's statistics after the item.
// Configuration: wr_en/wr_index/wr_data, to be written only while the block is idle;
// the block itself does not enforce this.
// Throughput: one item per cycle while out_stall is low; the us-to-ms reciprocal
// divider is a five-stage pipeline ahead of the statistics register.
// Reset: statistics cleared, registers at their defaults, pipeline empty.
// Stall: a stalled result holds; stages behind it keep filling, and in_stall
// rises once all six stages hold beats.
`default_nettype none
module audio_stream_quality_monitor import asqm_pkg::*; #(
	parameter int SAMPLE_BITS = 20,
	parameter int COUNT_BITS  = 32,
	parameter int CHANNELS    = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [CFG_INDEX_BITS-1:0]     wr_index,
	input  wire logic [CFG_DATA_BITS-1:0]      wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    action,
	input  wire logic                          channel,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic [TS_BITS-1:0]            timestamp_us,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [COUNT_BITS-1:0]              sample_count,
	output logic [SAMPLE_BITS-1:0]             peak_abs,
	output logic [COUNT_BITS-1:0]              clip_count,
	output logic [COUNT_BITS-1:0]              silent_count,
	output logic [COUNT_BITS-1:0]              jump_count,
	output logic [COUNT_BITS-1:0]              packet_count,
	output logic [COUNT_BITS-1:0]              gap_count,
	output logic [COUNT_BITS-1:0]              longest_gap_ms
);

	localparam int CH_IDX = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LW = (SAMPLE_BITS + 1 > JITTER_BITS) ? SAMPLE_BITS + 1 : JITTER_BITS;

	typedef struct packed {
		logic [1:0]             action;
		logic                   channel;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   gap_valid;
	} item_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	// configuration
	logic                      enabled_q;
	logic [LEVEL_BITS-1:0]     clip_level_q;
	logic [LEVEL_BITS-1:0]     silence_level_q;
	logic [JITTER_BITS-1:0]    jitter_delta_q;
	logic [GAP_LIMIT_BITS-1:0] gap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= 1'b0;
			clip_level_q    <= CLIP_LEVEL_RST;
			silence_level_q <= SILENCE_LEVEL_RST;
			jitter_delta_q  <= JITTER_DELTA_RST;
			gap_limit_q     <= GAP_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ENABLED:       enabled_q       <= wr_data[0];
				CFG_CLIP_LEVEL:    clip_level_q    <= wr_data[LEVEL_BITS-1:0];
				CFG_SILENCE_LEVEL: silence_level_q <= wr_data[LEVEL_BITS-1:0];
				CFG_JITTER_DELTA:  jitter_delta_q  <= wr_data[JITTER_BITS-1:0];
				CFG_GAP_LIMIT:     gap_limit_q     <= wr_data[GAP_LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow
	logic  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, out_valid_q;
	item_t item_s1, item_s2, item_s3, item_s4, item_s5;
	logic  ld1, ld2, ld3, ld4, ld5, ld_out, free1;

	always_comb begin
		ld_out = valid_s5 && (!out_valid_q || !out_stall);
		ld5    = valid_s4 && (!valid_s5 || ld_out);
		ld4    = valid_s3 && (!valid_s4 || ld5);
		ld3    = valid_s2 && (!valid_s3 || ld4);
		ld2    = valid_s1 && (!valid_s2 || ld3);
		free1  = !valid_s1 || ld2;
		ld1    = in_valid && free1;
	end

	assign in_stall = !free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= ld1 || (valid_s1 && !ld2);
			valid_s2    <= ld2 || (valid_s2 && !ld3);
			valid_s3    <= ld3 || (valid_s3 && !ld4);
			valid_s4    <= ld4 || (valid_s4 && !ld5);
			valid_s5    <= ld5 || (valid_s5 && !ld_out);
			out_valid_q <= ld_out || (out_valid_q && out_stall);
		end
	end

	// packet time tracking at the input
	logic [TS_BITS-1:0] prev_time_q [CHANNELS];
	logic [CHANNELS-1:0] has_prev_q;
	logic [CH_IDX-1:0]   idx_in;
	logic                ok_in;
	logic                pkt_in;
	logic [TS_BITS:0]    diff_w;
	logic [X_BITS-1:0]   diff_x;
	item_t               item_in;

	always_comb begin
		idx_in  = CH_IDX'(channel);
		ok_in   = 32'(channel) < CHANNELS;
		pkt_in  = enabled_q && ok_in && (action == ACT_PACKET);
		diff_w  = {1'b0, timestamp_us} - {1'b0, prev_time_q[idx_in]};
		diff_x  = diff_w[TS_BITS] ? '0 : diff_w[TS_BITS-1:TS_SHIFT];
		item_in.action    = action;
		item_in.channel   = channel;
		item_in.sample    = sample;
		item_in.gap_valid = pkt_in && has_prev_q[idx_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_prev_q <= '0;
		end else if (ld1) begin
			if (action == ACT_CLEAR) begin
				has_prev_q <= '0;
			end else if (pkt_in) begin
				has_prev_q[idx_in] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && pkt_in) begin
			prev_time_q[idx_in] <= timestamp_us;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) item_s1 <= item_in;
		if (ld2) item_s2 <= item_s1;
		if (ld3) item_s3 <= item_s2;
		if (ld4) item_s4 <= item_s3;
		if (ld5) item_s5 <= item_s4;
	end

	div_ctl_t              div_ctl;
	logic [COUNT_BITS-1:0] gap_s5;

	assign div_ctl.load = {ld5, ld4, ld3, ld2, ld1};

	asqm_gap_div #(
		.COUNT_BITS (COUNT_BITS)
	) u_gap_div (
		.clk    (clk),
		.ctl    (div_ctl),
		.diff_x (diff_x),
		.gap    (gap_s5)
	);

	// per-channel statistics, updated as a beat enters the result register
	logic [COUNT_BITS-1:0]  sample_total_q [CHANNELS];
	logic [SAMPLE_BITS-1:0] peak_store_q   [CHANNELS];
	logic [COUNT_BITS-1:0]  clip_total_q   [CHANNELS];
	logic [COUNT_BITS-1:0]  silent_total_q [CHANNELS];
	logic [COUNT_BITS-1:0]  jitter_total_q [CHANNELS];
	logic [COUNT_BITS-1:0]  packet_total_q [CHANNELS];
	logic [COUNT_BITS-1:0]  gap_total_q    [CHANNELS];
	logic [COUNT_BITS-1:0]  gap_max_q      [CHANNELS];
	logic [SAMPLE_BITS-1:0] prev_sample_q  [CHANNELS];

	logic [CH_IDX-1:0]        idx5;
	logic                     ok5;
	logic                     clear5;
	logic [COUNT_BITS-1:0]    n_samples, n_clip, n_silent, n_jitter;
	logic [COUNT_BITS-1:0]    n_packets, n_gaps, n_gap_max;
	logic [SAMPLE_BITS-1:0]   n_peak, n_prev;
	logic signed [SAMPLE_BITS:0] s_ext, p_ext, d;
	logic [SAMPLE_BITS:0]     mag_w, dmag;
	logic [SAMPLE_BITS-1:0]   mag;

	always_comb begin
		idx5   = CH_IDX'(item_s5.channel);
		ok5    = 32'(item_s5.channel) < CHANNELS;
		clear5 = item_s5.action == ACT_CLEAR;

		n_samples = ok5 ? sample_total_q[idx5] : '0;
		n_peak    = ok5 ? peak_store_q[idx5]   : '0;
		n_clip    = ok5 ? clip_total_q[idx5]   : '0;
		n_silent  = ok5 ? silent_total_q[idx5] : '0;
		n_jitter  = ok5 ? jitter_total_q[idx5] : '0;
		n_packets = ok5 ? packet_total_q[idx5] : '0;
		n_gaps    = ok5 ? gap_total_q[idx5]    : '0;
		n_gap_max = ok5 ? gap_max_q[idx5]      : '0;
		n_prev    = ok5 ? prev_sample_q[idx5]  : '0;

		s_ext = $signed({item_s5.sample[SAMPLE_BITS-1], item_s5.sample});
		p_ext = $signed({n_prev[SAMPLE_BITS-1], n_prev});
		mag_w = s_ext[SAMPLE_BITS] ? $unsigned(-s_ext) : $unsigned(s_ext);
		mag   = mag_w[SAMPLE_BITS-1:0];
		d     = s_ext - p_ext;
		dmag  = d[SAMPLE_BITS] ? $unsigned(-d) : $unsigned(d);

		if (enabled_q && item_s5.action == ACT_SAMPLE) begin
			n_samples = sat_inc(n_samples);
			if (mag > n_peak) n_peak = mag;
			if (LW'(mag) > LW'(clip_level_q)) n_clip = sat_inc(n_clip);
			if (LW'(mag) < LW'(silence_level_q)) n_silent = sat_inc(n_silent);
			if (LW'(dmag) > LW'(jitter_delta_q)) n_jitter = sat_inc(n_jitter);
			n_prev = item_s5.sample;
		end else if (enabled_q && item_s5.action == ACT_PACKET) begin
			n_packets = sat_inc(n_packets);
			if (item_s5.gap_valid) begin
				if (gap_s5 > COUNT_BITS'(gap_limit_q)) n_gaps = sat_inc(n_gaps);
				if (gap_s5 > n_gap_max) n_gap_max = gap_s5;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sample_total_q[i] <= '0;
				peak_store_q[i]   <= '0;
				clip_total_q[i]   <= '0;
				silent_total_q[i] <= '0;
				jitter_total_q[i] <= '0;
				packet_total_q[i] <= '0;
				gap_total_q[i]    <= '0;
				gap_max_q[i]      <= '0;
				prev_sample_q[i]  <= '0;
			end
		end else if (ld_out) begin
			if (clear5) begin
				for (int i = 0; i < CHANNELS; i++) begin
					sample_total_q[i] <= '0;
					peak_store_q[i]   <= '0;
					clip_total_q[i]   <= '0;
					silent_total_q[i] <= '0;
					jitter_total_q[i] <= '0;
					packet_total_q[i] <= '0;
					gap_total_q[i]    <= '0;
					gap_max_q[i]      <= '0;
					prev_sample_q[i]  <= '0;
				end
			end else if (ok5) begin
				sample_total_q[idx5] <= n_samples;
				peak_store_q[idx5]   <= n_peak;
				clip_total_q[idx5]   <= n_clip;
				silent_total_q[idx5] <= n_silent;
				jitter_total_q[idx5] <= n_jitter;
				packet_total_q[idx5] <= n_packets;
				gap_total_q[idx5]    <= n_gaps;
				gap_max_q[idx5]      <= n_gap_max;
				prev_sample_q[idx5]  <= n_prev;
			end
		end
	end

	// result register
	logic [COUNT_BITS-1:0]  sample_count_q, clip_count_q, silent_count_q, jump_count_q;
	logic [COUNT_BITS-1:0]  packet_count_q, gap_count_q, longest_gap_ms_q;
	logic [SAMPLE_BITS-1:0] peak_abs_q;
	logic                   zero5;

	assign zero5 = clear5 || !ok5;

	always_ff @(posedge clk) begin
		if (ld_out) begin
			sample_count_q   <= zero5 ? '0 : n_samples;
			peak_abs_q       <= zero5 ? '0 : n_peak;
			clip_count_q     <= zero5 ? '0 : n_clip;
			silent_count_q   <= zero5 ? '0 : n_silent;
			jump_count_q     <= zero5 ? '0 : n_jitter;
			packet_count_q   <= zero5 ? '0 : n_packets;
			gap_count_q      <= zero5 ? '0 : n_gaps;
			longest_gap_ms_q <= zero5 ? '0 : n_gap_max;
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_count   = sample_count_q;
	assign peak_abs       = peak_abs_q;
	assign clip_count     = clip_count_q;
	assign silent_count   = silent_count_q;
	assign jump_count     = jump_count_q;
	assign packet_count   = packet_count_q;
	assign gap_count      = gap_count_q;
	assign longest_gap_ms = longest_gap_ms_q;

endmodule
`default_nettype wire

>>> hdl/asqm_gap_div.sv
`default_nettype none
module asqm_gap_div import asqm_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire div_ctl_t              ctl,
	input  wire logic [X_BITS-1:0]     diff_x,
	output logic      [COUNT_BITS-1:0] gap
);

	localparam int GW = (COUNT_BITS > QUOT_BITS) ? COUNT_BITS : QUOT_BITS;
	localparam int P1_BITS = XH_BITS + RECIP_BITS;
	localparam int P2_BITS = Y_BITS + RECIP_BITS;

	function automatic logic [31:0] times_125(input logic [31:0] v);
		return (v << 7) - (v << 1) - v;
	endfunction

	logic [X_BITS-1:0]   x_s1;
	logic [Q1_BITS-1:0]  q1e_s2;
	logic [XH_BITS-1:0]  xh_s2;
	logic [XL_BITS-1:0]  xl_s2;
	logic [Q1_BITS-1:0]  q1_s3;
	logic [Y_BITS-1:0]   y_s3;
	logic [Q1_BITS-1:0]  q1_s4;
	logic [Q2_BITS-1:0]  q2e_s4;
	logic [Y_BITS-1:0]   y_s4;
	logic [COUNT_BITS-1:0] gap_s5;

	logic [P1_BITS-1:0]  p1;
	logic [31:0]         r1_w;
	logic [Q1_BITS-1:0]  q1;
	logic [REM_BITS-1:0] r1;
	logic [P2_BITS-1:0]  p2;
	logic [31:0]         r2_w;
	logic [Q2_BITS-1:0]  q2;
	logic [GW-1:0]       quot_w;
	logic [GW-1:0]       cnt_max_w;

	always_comb begin
		p1   = P1_BITS'(x_s1[X_BITS-1:XL_BITS]) * P1_BITS'(RECIP_125);
		r1_w = 32'(xh_s2) - times_125(32'(q1e_s2));
		if (r1_w >= DIVISOR) begin
			q1 = q1e_s2 + Q1_BITS'(1);
			r1 = REM_BITS'(r1_w - DIVISOR);
		end else begin
			q1 = q1e_s2;
			r1 = REM_BITS'(r1_w);
		end
		p2   = P2_BITS'(y_s3) * P2_BITS'(RECIP_125);
		r2_w = 32'(y_s4) - times_125(32'(q2e_s4));
		q2   = (r2_w >= DIVISOR) ? q2e_s4 + Q2_BITS'(1) : q2e_s4;
		quot_w    = GW'({q1_s4, q2});
		cnt_max_w = GW'({COUNT_BITS{1'b1}});
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			x_s1 <= diff_x;
		end
		if (ctl.load[1]) begin
			q1e_s2 <= p1[RECIP_SHIFT +: Q1_BITS];
			xh_s2  <= x_s1[X_BITS-1:XL_BITS];
			xl_s2  <= x_s1[XL_BITS-1:0];
		end
		if (ctl.load[2]) begin
			q1_s3 <= q1;
			y_s3  <= {r1, xl_s2};
		end
		if (ctl.load[3]) begin
			q1_s4  <= q1_s3;
			q2e_s4 <= p2[RECIP_SHIFT +: Q2_BITS];
			y_s4   <= y_s3;
		end
		if (ctl.load[4]) begin
			gap_s5 <= (quot_w > cnt_max_w) ? COUNT_BITS'(cnt_max_w) : COUNT_BITS'(quot_w);
		end
	end

	assign gap = gap_s5;

endmodule
`default_nettype wire

>>> hdl/asqm_checker.sv
`default_nettype none
module asqm_checker #(
	parameter int SAMPLE_BITS = 20,
	parameter int COUNT_BITS  = 32
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [COUNT_BITS-1:0]  sample_count,
	input wire logic [SAMPLE_BITS-1:0] peak_abs,
	input wire logic [COUNT_BITS-1:0]  clip_count,
	input wire logic [COUNT_BITS-1:0]  silent_count,
	input wire logic [COUNT_BITS-1:0]  jump_count,
	input wire logic [COUNT_BITS-1:0]  packet_count,
	input wire logic [COUNT_BITS-1:0]  gap_count
);

	localparam logic [SAMPLE_BITS-1:0] PEAK_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// input backs up only behind a stalled result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a stalled result beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_count)
			&& $stable(peak_abs) && $stable(packet_count) && $stable(gap_count))
		else $error("stalled result beat changed");

	a_sample_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> clip_count <= sample_count && silent_count <= sample_count
			&& jump_count <= sample_count)
		else $error("event count above sample count");

	a_packet_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gap_count <= packet_count && peak_abs <= PEAK_MAX)
		else $error("gap count above packet count or peak out of range");

endmodule

bind audio_stream_quality_monitor asqm_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.COUNT_BITS  (COUNT_BITS)
) u_asqm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sample_count (sample_count),
	.peak_abs     (peak_abs),
	.clip_count   (clip_count),
	.silent_count (silent_count),
	.jump_count   (jump_count),
	.packet_count (packet_count),
	.gap_count    (gap_count)
);
`default_nettype wire
